// ----- src/tree_lca_binary_lifting_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the tree ancestor query core
// Shared property shapes, used one per line in the checker.
// ----------------------------------------------------------------------------
`ifndef TREE_LCA_BINARY_LIFTING_CORE_DEFINES_SVH
`define TREE_LCA_BINARY_LIFTING_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TLCA_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLCA_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/tlca_pkg.sv -----
// ----------------------------------------------------------------------------
// tlca_pkg
// Types and constants shared by the tree ancestor query core.
// ----------------------------------------------------------------------------
`default_nettype none

package tlca_pkg;

	localparam int NODE_W = 11;
	// Row field wide enough for up to thirty-one lifting levels plus the depth row.
	localparam int ROW_W  = 5;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [ROW_W-1:0]  row_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLR,
		ST_POP,
		ST_POP_RD,
		ST_U_DEP,
		ST_E_RD,
		ST_E_DEC,
		ST_V_CHK,
		ST_V_ANC,
		ST_V_DEP,
		ST_F_RD1,
		ST_F_RD2,
		ST_F_WR,
		ST_QUERY,
		ST_Q_DA,
		ST_Q_DB,
		ST_Q_SWAP,
		ST_L_RD1,
		ST_L_RD2,
		ST_L_CMP,
		ST_Q_EQ,
		ST_U_RD1,
		ST_U_RD2,
		ST_U_CMP,
		ST_P_RD,
		ST_P_WAIT,
		ST_DONE
	} state_t;

	// Access to the ancestor/depth table: one write and one read per cycle.
	typedef struct packed {
		logic  we;
		row_t  wrow;
		node_t wnode;
		node_t wdata;
		row_t  rrow;
		node_t rnode;
	} anc_req_t;

	// Edge appends and walk stack operations.
	typedef struct packed {
		logic  append;
		node_t a;
		node_t b;
		logic  push;
		node_t push_node;
		logic  pop;
	} walk_req_t;

endpackage

`default_nettype wire

// ----- src/tree_lca_binary_lifting_core.sv -----
// Query on a built tree: each of the two lifting passes does two table reads and a
// compare per level; only in the first pass does the second read depend on the first.
// Edge beats are taken one per cycle while the core is idle. The first query first
// builds the tree: it initializes every row of each node, scans the stored edges
// for each visited node, and then fills the table level by level.
// Reset clears the control state, the edge count and node_count (to 1).
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting_core
// Lowest common ancestor queries by binary lifting over a tree rooted at 1.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_lca_binary_lifting_core import tlca_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [10:0] cfg_wr_data,   // node_count
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // node_a [10:0], node_b [21:11]
	input  wire logic        s_axis_tuser,  // kind
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // common_ancestor [10:0]
	output logic             m_axis_tuser   // bad_node
);

	localparam int CW     = $clog2(MAX_NODES);
	localparam int LimCap = (MAX_NODES > 2047) ? 2047 : MAX_NODES;
	localparam row_t DepRow = ROW_W'(LEVELS);
	localparam row_t TopLvl = ROW_W'(LEVELS - 1);
	localparam node_t One   = NODE_W'(1);

	state_t     st_q, st_d;
	logic       built_q;
	node_t      node_count_q;
	logic       m_valid_q;
	node_t      m_data_q;
	logic       m_bad_q;

	node_t      a_q, b_q, u_q, v_q, j_q, up_q, ua_q, res_q;
	node_t      du_q, da_q;
	logic       bad_q;
	row_t       row_q, k_q;
	logic [CW-1:0] e_q;

	node_t      lim, jmax, in_a, in_b, v_sel;
	logic       accept, query_beat, in_bad, hit, e_last, ld;

	anc_req_t   anc_req;
	node_t      anc_rdata;
	walk_req_t  walk_req;
	node_t      edge_x, edge_y, stack_node;
	logic [CW-1:0] edge_total;
	logic       stack_empty;

	tlca_anc_mem #(.MAX_NODES(MAX_NODES), .LEVELS(LEVELS)) u_anc (
		.clk   (clk),
		.req   (anc_req),
		.rdata (anc_rdata)
	);

	tlca_walk_mem #(.MAX_NODES(MAX_NODES)) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (walk_req),
		.edge_idx    (e_q),
		.edge_x      (edge_x),
		.edge_y      (edge_y),
		.edge_total  (edge_total),
		.stack_empty (stack_empty),
		.stack_node  (stack_node)
	);

	assign lim  = (node_count_q > NODE_W'(LimCap)) ? NODE_W'(LimCap) : node_count_q;
	assign jmax = (lim == '0) ? One : lim;

	assign s_axis_tready = (st_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign query_beat    = accept && s_axis_tuser;
	assign in_a          = s_axis_tdata[10:0];
	assign in_b          = s_axis_tdata[21:11];
	assign in_bad        = (in_a == '0) || (in_a > lim) || (in_b == '0) || (in_b > lim);

	// The other end of a stored edge that touches the node being expanded.
	assign v_sel  = (edge_x == u_q) ? edge_y : edge_x;
	assign hit    = ((edge_x == u_q) || (edge_y == u_q)) && (v_sel != '0) && (v_sel <= lim);
	assign e_last = ((e_q + CW'(1)) == edge_total);
	assign ld     = !m_valid_q || m_axis_tready;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (query_beat) st_d = built_q ? ST_QUERY : ST_CLR;
			ST_CLR:    if (row_q == DepRow && j_q == jmax) st_d = ST_POP;
			ST_POP: begin
				if (!stack_empty) begin
					st_d = ST_POP_RD;
				end else if (LEVELS > 1 && lim >= NODE_W'(2)) begin
					st_d = ST_F_RD1;
				end else begin
					st_d = ST_QUERY;
				end
			end
			ST_POP_RD: st_d = ST_U_DEP;
			ST_U_DEP:  st_d = (edge_total == '0) ? ST_POP : ST_E_RD;
			ST_E_RD:   st_d = ST_E_DEC;
			ST_E_DEC:  st_d = hit ? ST_V_CHK : (e_last ? ST_POP : ST_E_RD);
			ST_V_CHK:  st_d = (anc_rdata == '0) ? ST_V_ANC : (e_last ? ST_POP : ST_E_RD);
			ST_V_ANC:  st_d = ST_V_DEP;
			ST_V_DEP:  st_d = e_last ? ST_POP : ST_E_RD;
			ST_F_RD1:  st_d = ST_F_RD2;
			ST_F_RD2:  st_d = ST_F_WR;
			ST_F_WR:   st_d = (j_q == lim && k_q == TopLvl) ? ST_QUERY : ST_F_RD1;
			ST_QUERY:  st_d = bad_q ? ST_DONE : ST_Q_DA;
			ST_Q_DA:   st_d = ST_Q_DB;
			ST_Q_DB:   st_d = ST_Q_SWAP;
			ST_Q_SWAP: st_d = ST_L_RD1;
			ST_L_RD1:  st_d = ST_L_RD2;
			ST_L_RD2:  st_d = ST_L_CMP;
			ST_L_CMP:  st_d = (k_q == '0) ? ST_Q_EQ : ST_L_RD1;
			ST_Q_EQ:   st_d = (a_q == b_q) ? ST_DONE : ST_U_RD1;
			ST_U_RD1:  st_d = ST_U_RD2;
			ST_U_RD2:  st_d = ST_U_CMP;
			ST_U_CMP:  st_d = (k_q == '0) ? ST_P_RD : ST_U_RD1;
			ST_P_RD:   st_d = ST_P_WAIT;
			ST_P_WAIT: st_d = ST_DONE;
			ST_DONE:   if (ld) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		anc_req  = '0;
		walk_req = '0;
		walk_req.a = in_a;
		walk_req.b = in_b;
		case (st_q)
			ST_IDLE: begin
				walk_req.append = accept && !s_axis_tuser && !built_q;
			end
			ST_CLR: begin
				// Node 1 is its own parent at every level and sits at depth 1.
				anc_req.we    = 1'b1;
				anc_req.wrow  = row_q;
				anc_req.wnode = j_q;
				anc_req.wdata = (j_q == One) ? One : '0;
				if (row_q == DepRow && j_q == jmax) begin
					walk_req.push      = 1'b1;
					walk_req.push_node = One;
				end
			end
			ST_POP: walk_req.pop = 1'b1;
			ST_POP_RD: begin
				anc_req.rrow  = DepRow;
				anc_req.rnode = stack_node;
			end
			ST_E_DEC: begin
				anc_req.rrow  = DepRow;
				anc_req.rnode = v_sel;
			end
			ST_V_ANC: begin
				anc_req.we    = 1'b1;
				anc_req.wnode = v_q;
				anc_req.wdata = u_q;
			end
			ST_V_DEP: begin
				anc_req.we         = 1'b1;
				anc_req.wrow       = DepRow;
				anc_req.wnode      = v_q;
				anc_req.wdata      = du_q + One;
				walk_req.push      = 1'b1;
				walk_req.push_node = v_q;
			end
			ST_F_RD1: begin
				anc_req.rrow  = k_q - ROW_W'(1);
				anc_req.rnode = j_q;
			end
			ST_F_RD2: begin
				anc_req.rrow  = k_q - ROW_W'(1);
				anc_req.rnode = anc_rdata;
			end
			ST_F_WR: begin
				anc_req.we    = 1'b1;
				anc_req.wrow  = k_q;
				anc_req.wnode = j_q;
				anc_req.wdata = anc_rdata;
			end
			ST_Q_DA: begin
				anc_req.rrow  = DepRow;
				anc_req.rnode = a_q;
			end
			ST_Q_DB: begin
				anc_req.rrow  = DepRow;
				anc_req.rnode = b_q;
			end
			ST_L_RD1: begin
				anc_req.rrow  = k_q;
				anc_req.rnode = b_q;
			end
			ST_L_RD2: begin
				anc_req.rrow  = DepRow;
				anc_req.rnode = anc_rdata;
			end
			ST_U_RD1: begin
				anc_req.rrow  = k_q;
				anc_req.rnode = a_q;
			end
			ST_U_RD2: begin
				anc_req.rrow  = k_q;
				anc_req.rnode = b_q;
			end
			ST_P_RD: begin
				anc_req.rnode = a_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			built_q      <= 1'b0;
			node_count_q <= One;
			m_valid_q    <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_wr_en) begin
				node_count_q <= cfg_wr_data;
			end
			if (st_q == ST_QUERY) begin
				built_q <= 1'b1;
			end
			if (st_q == ST_DONE && ld) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				if (query_beat) begin
					a_q   <= in_a;
					b_q   <= in_b;
					bad_q <= in_bad;
					j_q   <= One;
					row_q <= '0;
				end
			end
			ST_CLR: begin
				if (row_q == DepRow) begin
					row_q <= '0;
					j_q   <= j_q + One;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end
			ST_POP: begin
				j_q <= NODE_W'(2);
				k_q <= ROW_W'(1);
			end
			ST_POP_RD: u_q <= stack_node;
			ST_U_DEP: begin
				du_q <= anc_rdata;
				e_q  <= '0;
			end
			ST_E_DEC: begin
				if (hit) begin
					v_q <= v_sel;
				end else if (!e_last) begin
					e_q <= e_q + CW'(1);
				end
			end
			ST_V_CHK: if (anc_rdata != '0 && !e_last) e_q <= e_q + CW'(1);
			ST_V_DEP: if (!e_last) e_q <= e_q + CW'(1);
			ST_F_WR: begin
				if (j_q == lim) begin
					j_q <= NODE_W'(2);
					k_q <= k_q + ROW_W'(1);
				end else begin
					j_q <= j_q + One;
				end
			end
			ST_QUERY: res_q <= '0;
			ST_Q_DB:  da_q  <= anc_rdata;
			ST_Q_SWAP: begin
				// Keep the shallower node in a and lift b.
				if (da_q > anc_rdata) begin
					a_q  <= b_q;
					b_q  <= a_q;
					da_q <= anc_rdata;
				end
				k_q <= TopLvl;
			end
			ST_L_RD2: up_q <= anc_rdata;
			ST_L_CMP: begin
				if (anc_rdata >= da_q) begin
					b_q <= up_q;
				end
				k_q <= k_q - ROW_W'(1);
			end
			ST_Q_EQ: begin
				res_q <= a_q;
				k_q   <= TopLvl;
			end
			ST_U_RD2: ua_q <= anc_rdata;
			ST_U_CMP: begin
				if (ua_q != anc_rdata) begin
					a_q <= ua_q;
					b_q <= anc_rdata;
				end
				k_q <= k_q - ROW_W'(1);
			end
			ST_P_WAIT: res_q <= anc_rdata;
			ST_DONE: begin
				if (ld) begin
					m_data_q <= res_q;
					m_bad_q  <= bad_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {5'b0, m_data_q};
	assign m_axis_tuser  = m_bad_q;

endmodule

`default_nettype wire

// ----- src/tlca_anc_mem.sv -----
// ----------------------------------------------------------------------------
// tlca_anc_mem
// Ancestor table and depth table in one synchronous memory, addressed by
// node number and row. Node 0 reads as zero in every row.
// ----------------------------------------------------------------------------
`default_nettype none

module tlca_anc_mem import tlca_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  wire logic     clk,
	input  wire anc_req_t req,
	output node_t         rdata
);

	localparam int AW    = $clog2(MAX_NODES);
	localparam int RW    = $clog2(LEVELS + 1);
	localparam int DEPTH = (LEVELS + 1) << AW;

	node_t               mem [DEPTH];
	logic [RW+AW-1:0]    waddr;
	logic [RW+AW-1:0]    raddr;
	node_t               rd_q;
	logic                rzero_q;

	function automatic logic [AW-1:0] node_idx(input node_t n);
		return AW'(AW'(n) - AW'(1));
	endfunction

	assign waddr = {req.wrow[RW-1:0], node_idx(req.wnode)};
	assign raddr = {req.rrow[RW-1:0], node_idx(req.rnode)};

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[waddr] <= req.wdata;
		end
		rd_q    <= mem[raddr];
		rzero_q <= (req.rnode == '0);
	end

	assign rdata = rzero_q ? '0 : rd_q;

endmodule

`default_nettype wire

// ----- src/tlca_walk_mem.sv -----
// ----------------------------------------------------------------------------
// tlca_walk_mem
// Edge store with its fill count, and the stack of the depth-first walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tlca_walk_mem import tlca_pkg::*; #(
	parameter int MAX_NODES = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire walk_req_t                    req,
	input  wire logic [$clog2(MAX_NODES)-1:0] edge_idx,
	output node_t                             edge_x,
	output node_t                             edge_y,
	output logic [$clog2(MAX_NODES)-1:0]      edge_total,
	output logic                              stack_empty,
	output node_t                             stack_node
);

	localparam int CW    = $clog2(MAX_NODES);
	localparam int EDGES = MAX_NODES - 1;
	localparam int EAW   = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int SAW   = $clog2(MAX_NODES);
	localparam int SPW   = $clog2(MAX_NODES + 1);

	logic [2*NODE_W-1:0] emem [EDGES];
	logic [2*NODE_W-1:0] edge_q;
	logic [CW-1:0]       total_q;
	node_t               stk [MAX_NODES];
	node_t               stk_q;
	logic [SPW-1:0]      top_q;
	logic [SPW-1:0]      top_m1;
	logic                do_append;
	logic                do_push;
	logic                do_pop;

	assign do_append = req.append && (total_q < CW'(EDGES));
	assign do_push   = req.push && (top_q < SPW'(MAX_NODES));
	assign do_pop    = req.pop && (top_q != '0);
	assign top_m1    = top_q - SPW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			top_q   <= '0;
		end else begin
			if (do_append) begin
				total_q <= total_q + CW'(1);
			end
			if (do_push) begin
				top_q <= top_q + SPW'(1);
			end else if (do_pop) begin
				top_q <= top_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_append) begin
			emem[total_q[EAW-1:0]] <= {req.b, req.a};
		end
		edge_q <= emem[edge_idx[EAW-1:0]];
		if (do_push) begin
			stk[top_q[SAW-1:0]] <= req.push_node;
		end
		stk_q <= stk[top_m1[SAW-1:0]];
	end

	assign edge_x      = edge_q[NODE_W-1:0];
	assign edge_y      = edge_q[2*NODE_W-1:NODE_W];
	assign edge_total  = total_q;
	assign stack_empty = (top_q == '0);
	assign stack_node  = stk_q;

endmodule

`default_nettype wire

// ----- src/tlca_checker.sv -----
// ----------------------------------------------------------------------------
// tlca_checker
// Port-level checks on the tree ancestor query core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tree_lca_binary_lifting_core_defines.svh"

module tlca_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [15:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	`TLCA_ASSERT_NXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result beat changed")
	`TLCA_ASSERT_IMP(a_bad_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0, "bad query must answer node 0")
	`TLCA_ASSERT_NXT(a_query_busy, clk, arst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser, !s_axis_tready, "input still open after a query beat")
	`TLCA_ASSERT_IMP(a_res_after_work, clk, arst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "result beat without query work")

endmodule

bind tree_lca_binary_lifting_core tlca_checker u_tlca_checker (.*);

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Testbench for the tree ancestor query core
// Loads a random tree with noise edges, then checks every query answer against
// an in-bench binary lifting predictor under random idling and back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import tlca_pkg::*;

	localparam int NMAX      = 1024;
	localparam int NLEV      = 10;
	localparam int STORE_MAX = NMAX - 1;
	localparam int TREE_SIZE = 300;
	localparam int CHAIN_LEN = 200;
	localparam longint CYCLE_LIMIT = 20_000_000;
	localparam bit KIND_EDGE  = 1'b0;
	localparam bit KIND_QUERY = 1'b1;

	typedef struct {
		node_t ancestor;
		logic  bad;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [10:0] cfg_wr_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;   // node_a [10:0], node_b [21:11]
	logic        s_axis_tuser;   // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // common_ancestor [10:0]
	logic        m_axis_tuser;   // bad_node

	tree_lca_binary_lifting_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// Predictor state.
	node_t   node_limit_reg;
	node_t   stored_a[$];
	node_t   stored_b[$];
	node_t   lift[1:NMAX][0:NLEV-1];
	int      level_of[1:NMAX];
	bit      tree_ready;
	answer_t answers_due[$];

	// Stimulus bookkeeping.
	int    tree_nodes[$];
	int    loose_nodes[$];
	node_t load_a[$];
	node_t load_b[$];

	int     mismatches;
	bit     quiet;
	int     hold_reqs;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	function automatic node_t lift_at(int v, int k);
		if (v < 1 || v > NMAX)
			return '0;
		return lift[v][k];
	endfunction

	function automatic int level_at(int v);
		if (v < 1 || v > NMAX)
			return 0;
		return level_of[v];
	endfunction

	function automatic int usable_nodes();
		return (node_limit_reg > NMAX) ? NMAX : int'(node_limit_reg);
	endfunction

	function automatic void build_lifting();
		int stack[$];
		int lim, u, v, x, y;
		lim = usable_nodes();
		for (int n = 1; n <= NMAX; n++) begin
			level_of[n] = 0;
			for (int k = 0; k < NLEV; k++)
				lift[n][k] = '0;
		end
		for (int k = 0; k < NLEV; k++)
			lift[1][k] = node_t'(1);
		level_of[1] = 1;
		stack = {stack, 1};
		while (stack.size() > 0) begin
			u = stack.pop_back();
			for (int e = 0; e < stored_a.size(); e++) begin
				x = int'(stored_a[e]);
				y = int'(stored_b[e]);
				if (x == u)
					v = y;
				else if (y == u)
					v = x;
				else
					continue;
				if (v < 1 || v > lim || level_of[v] != 0)
					continue;
				lift[v][0] = node_t'(u);
				level_of[v] = level_of[u] + 1;
				stack = {stack, v};
			end
		end
		for (int k = 1; k < NLEV; k++)
			for (int j = 2; j <= lim; j++)
				lift[j][k] = lift_at(int'(lift_at(j, k - 1)), k - 1);
		tree_ready = 1'b1;
	endfunction

	function automatic node_t common_root(int a, int b);
		int t, up, ua, ub;
		if (level_at(a) > level_at(b)) begin
			t = a;
			a = b;
			b = t;
		end
		for (int k = NLEV - 1; k >= 0; k--) begin
			up = int'(lift_at(b, k));
			if (level_at(up) >= level_at(a))
				b = up;
		end
		if (a == b)
			return node_t'(a);
		for (int k = NLEV - 1; k >= 0; k--) begin
			ua = int'(lift_at(a, k));
			ub = int'(lift_at(b, k));
			if (ua != ub) begin
				a = ua;
				b = ub;
			end
		end
		return lift_at(a, 0);
	endfunction

	function automatic void predict_beat(bit kind, node_t a, node_t b);
		answer_t ans;
		int lim;
		if (kind == KIND_EDGE) begin
			if (!tree_ready && stored_a.size() < STORE_MAX) begin
				stored_a = {stored_a, a};
				stored_b = {stored_b, b};
			end
			return;
		end
		if (!tree_ready)
			build_lifting();
		lim = usable_nodes();
		if (a < 1 || a > lim || b < 1 || b > lim) begin
			ans.ancestor = '0;
			ans.bad = 1'b1;
		end else begin
			ans.ancestor = common_root(int'(a), int'(b));
			ans.bad = 1'b0;
		end
		answers_due = {answers_due, ans};
	endfunction

	// Result side: random stall bursts plus requested long hold-offs.
	int rx_gap;
	int hold_left;
	int hold_taken;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_gap = 0;
			hold_left = 0;
			hold_taken = 0;
		end else begin
			if (hold_taken != hold_reqs) begin
				hold_taken = hold_reqs;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				rx_gap = $urandom_range(0, 12);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected answer: ancestor %0d bad %0d",
						m_axis_tdata[10:0], m_axis_tuser);
			end else begin
				want = answers_due.pop_front();
				if (m_axis_tdata[10:0] !== want.ancestor || m_axis_tuser !== want.bad) begin
					mismatches++;
					if (mismatches <= 10)
						$display("answer mismatch: expected %0d/%0d, got %0d/%0d",
							want.ancestor, want.bad, m_axis_tdata[10:0], m_axis_tuser);
				end
			end
		end
	end

	task automatic send_beat(bit kind, node_t a, node_t b);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 13);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= {2'b00, b, a};
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_beat(kind, a, b);
	endtask

	// Sender pause: all answers in, then the query latency once more since
	// edge beats leave nothing behind to wait for.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_node_count(logic [10:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		node_limit_reg = value;
	endtask

	function automatic int pick_tree();
		return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
	endfunction

	function automatic int pick_loose();
		return loose_nodes[$urandom_range(0, loose_nodes.size() - 1)];
	endfunction

	function automatic void add_edge(int a, int b);
		if ($urandom_range(0, 1)) begin
			load_a = {load_a, node_t'(a)};
			load_b = {load_b, node_t'(b)};
		end else begin
			load_a = {load_a, node_t'(b)};
			load_b = {load_b, node_t'(a)};
		end
	endfunction

	task automatic send_query(int a, int b);
		send_beat(KIND_QUERY, node_t'(a), node_t'(b));
	endtask

	task automatic test_config_before_build();
		write_node_count(11'd5);
		write_node_count(11'd2047);
		write_node_count(11'd0);
		write_node_count(11'd1024);
	endtask

	// A long chain for deep lifting, the rest hung off random earlier nodes,
	// plus loops, repeats, out-of-range endpoints and an unreachable forest
	// that fills the edge store.
	task automatic test_edge_load();
		bit taken[1:NMAX];
		int n, j, t;
		node_t sa, sb;
		for (int i = 1; i <= NMAX; i++)
			taken[i] = 1'b0;
		tree_nodes = {tree_nodes, 1};
		tree_nodes = {tree_nodes, 1024};
		tree_nodes = {tree_nodes, 2};
		taken[1] = 1'b1;
		taken[1024] = 1'b1;
		taken[2] = 1'b1;
		while (tree_nodes.size() < TREE_SIZE) begin
			n = $urandom_range(2, NMAX);
			if (!taken[n]) begin
				taken[n] = 1'b1;
				tree_nodes = {tree_nodes, n};
			end
		end
		for (int i = 2; i <= NMAX; i++)
			if (!taken[i])
				loose_nodes = {loose_nodes, i};
		for (int i = 1; i < TREE_SIZE; i++)
			add_edge(tree_nodes[i < CHAIN_LEN ? i - 1 : $urandom_range(0, i - 1)], tree_nodes[i]);
		add_edge(1, 1);
		add_edge(pick_tree(), pick_tree());
		add_edge(pick_tree(), pick_tree());
		add_edge(tree_nodes[5], tree_nodes[4]);
		add_edge(1, 0);
		add_edge(1, 2047);
		add_edge(tree_nodes[10], 1025);
		for (int i = 0; i < load_a.size(); i++) begin
			j = $urandom_range(0, load_a.size() - 1);
			sa = load_a[i]; load_a[i] = load_a[j]; load_a[j] = sa;
			sb = load_b[i]; load_b[i] = load_b[j]; load_b[j] = sb;
		end
		while (load_a.size() < STORE_MAX)
			add_edge(pick_loose(), pick_loose());
		// Store full: these reach new nodes but must be dropped.
		add_edge(1, loose_nodes[0]);
		add_edge(tree_nodes[3], loose_nodes[1]);
		t = load_a.size();
		for (int i = 0; i < t; i++)
			send_beat(KIND_EDGE, load_a[i], load_b[i]);
	endtask

	task automatic test_directed_queries();
		send_query(1, 1);
		send_query(tree_nodes[CHAIN_LEN - 1], tree_nodes[TREE_SIZE - 1]);
		send_query(tree_nodes[CHAIN_LEN - 1], 1);
		send_query(1024, 2);
		send_query(2, 2);
		send_query(loose_nodes[0], 1);
		send_query(loose_nodes[2], loose_nodes[3]);
		send_query(0, 1);
		send_query(1, 0);
		send_query(2047, 1024);
		send_query(1025, 1);
		send_query(tree_nodes[CHAIN_LEN - 1], tree_nodes[CHAIN_LEN - 2]);
		send_beat(KIND_EDGE, 11'd1, node_t'(loose_nodes[4]));
		send_query(loose_nodes[4], 1);
	endtask

	task automatic random_queries(int count);
		int r, a, b;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				send_beat(KIND_EDGE, node_t'($urandom_range(0, 2047)),
					node_t'($urandom_range(0, 2047)));
				continue;
			end
			a = (r < 16) ? pick_tree() : (r < 18) ? pick_loose() : $urandom_range(0, 2047);
			r = $urandom_range(0, 19);
			b = (r < 16) ? pick_tree() : (r < 18) ? pick_loose() : $urandom_range(0, 2047);
			send_query(a, b);
		end
	endtask

	task automatic test_backpressure();
		hold_reqs <= hold_reqs + 1;
		random_queries(40);
		drain();
	endtask

	task automatic test_node_limits();
		write_node_count(11'd1);
		send_query(1, 1);
		random_queries(40);
		write_node_count(11'd0);
		send_query(1, 1);
		random_queries(20);
		write_node_count(11'd2047);
		send_query(1024, 1);
		random_queries(40);
		write_node_count(11'd300);
		random_queries(40);
		write_node_count(11'd1024);
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		node_limit_reg = 11'd1;
		tree_ready    = 1'b0;
		mismatches    = 0;
		quiet         = 1'b0;
		hold_reqs     = 0;
		cycles        = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_config_before_build();
		test_edge_load();
		test_directed_queries();
		random_queries(60);
		test_backpressure();
		test_node_limits();
		random_queries(50);
		quiet <= 1'b1;
		random_queries(60);

		drain();
		repeat (100) @(posedge clk);
		if (mismatches == 0 && answers_due.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+src
src/tlca_pkg.sv
src/tlca_anc_mem.sv
src/tlca_walk_mem.sv
src/tree_lca_binary_lifting_core.sv
src/tlca_checker.sv
dv/tb.sv
